/* rtl/core/cbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    // number of 1K pattern windows
    localparam int CHR_WINDOWS_DEF = 8;

    // item kinds
    localparam logic [2:0] KIND_CPU_RD = 3'd0;
    localparam logic [2:0] KIND_CPU_WR = 3'd1;
    localparam logic [2:0] KIND_PPU_RD = 3'd2;
    localparam logic [2:0] KIND_PPU_WR = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    // result targets
    localparam logic [2:0] TGT_NONE   = 3'd0;
    localparam logic [2:0] TGT_PRGROM = 3'd1;
    localparam logic [2:0] TGT_PRGRAM = 3'd2;
    localparam logic [2:0] TGT_CHRROM = 3'd3;
    localparam logic [2:0] TGT_NTRAM  = 3'd4;
    localparam logic [2:0] TGT_REG    = 3'd5;

    // chip variants
    localparam logic [1:0] VAR_FULL   = 2'd0;
    localparam logic [1:0] VAR_SIMPLE = 2'd1;
    localparam logic [1:0] VAR_MIRROR = 2'd2;
    localparam logic [1:0] VAR_ALIAS  = 2'd3;

    // mirroring modes
    localparam logic [1:0] MIR_SINGLE_LO = 2'd0;
    localparam logic [1:0] MIR_VERT      = 2'd1;
    localparam logic [1:0] MIR_SINGLE_HI = 2'd2;
    localparam logic [1:0] MIR_HORIZ     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_CHIP_VARIANT = 2'd0;
    localparam logic [1:0] REG_INIT_MIRROR  = 2'd1;
    localparam logic [1:0] REG_CHR_ROM_MASK = 2'd2;
    localparam logic [1:0] REG_PRG_LAST     = 2'd3;

    localparam logic [7:0]  NT_RAM_SEL   = 8'hE0;
    localparam logic [14:0] IRQ_COUNT_MAX = 15'h7FFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  target;
        logic [18:0] mapped_address;
        logic        write_strobe;
        logic [7:0]  read_data;
        logic        irq_line;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/core/cartridge_bank_mapper_with_irq_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Cartridge bank mapper with interval IRQ, three chip variants chosen by the
// chip_variant register. Each input transaction (CPU read/write, PPU
// read/write or CPU cycle tick) is translated: the bank, nametable and IRQ
// state is updated at the clock edge that accepts the transaction, and the
// result is captured in an output register, so it appears in the cycle after
// acceptance. One transaction is taken every clock cycle while the output
// register is free; the output register decouples the two sides, so input is
// still accepted while a result waits as long as the consumer takes it in the
// same cycle. The APB port (pready always high, registers at byte offsets 0,
// 4, 8, 12) is to be written only while no transaction is in flight.
module cartridge_bank_mapper_with_irq_unit #(
    parameter int CHR_WINDOWS = cbm_pkg::CHR_WINDOWS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire cbm_pkg::t_in_item i_in_data,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output cbm_pkg::t_out_item     o_out_data,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import cbm_pkg::*;

    localparam int CW_W  = $clog2(CHR_WINDOWS);
    localparam int CW_LO = CHR_WINDOWS / 2;

    // configuration registers
    logic [1:0]  r_chip_variant;
    logic        r_init_mirror;
    logic [17:0] r_chr_rom_mask;
    logic [5:0]  r_prg_last;

    // mapper state
    logic [5:0]  r_prg_bank [3];
    logic [7:0]  r_chr_bank [CHR_WINDOWS];
    logic [7:0]  r_nt_sel   [4];
    logic        r_low_en;
    logic        r_high_en;
    logic [1:0]  r_mirror;
    logic [14:0] r_irq_count;
    logic        r_irq_enabled;
    logic        r_irq_pending;

    logic [5:0]  n_prg_bank [3];
    logic [7:0]  n_chr_bank [CHR_WINDOWS];
    logic [7:0]  n_nt_sel   [4];
    logic        n_low_en;
    logic        n_high_en;
    logic [1:0]  n_mirror;
    logic [14:0] n_irq_count;
    logic        n_irq_enabled;
    logic        n_irq_pending;

    // output register
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;

    logic        accept;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // ------------------------------------------------------------------
    // handshake: the output register frees up when its result is taken
    // ------------------------------------------------------------------
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // APB configuration access
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            REG_CHIP_VARIANT: prdata = {30'd0, r_chip_variant};
            REG_INIT_MIRROR:  prdata = {31'd0, r_init_mirror};
            REG_CHR_ROM_MASK: prdata = {14'd0, r_chr_rom_mask};
            REG_PRG_LAST:     prdata = {26'd0, r_prg_last};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // translation and state update for one transaction
    // ------------------------------------------------------------------
    logic [2:0]    kind;
    logic [15:0]   a;
    logic [7:0]    v;
    logic [1:0]    var_eff;
    logic          is_full;
    logic [13:0]   p;
    logic [9:0]    off;
    logic          ws;
    logic [CW_W-1:0] chr_win;
    logic [CW_W-1:0] chr_wr_win;
    logic [7:0]    chr_b;
    logic          chr_en;
    logic [1:0]    nt_n;
    logic [7:0]    nt_s;
    logic [7:0]    rom_bank;
    logic [17:0]   rom_base;
    logic [18:0]   rom_addr;
    logic [1:0]    mir_eff;
    logic          page;
    logic [5:0]    prg_sel;
    logic [14:0]   cnt_inc;

    always_comb begin
        kind     = i_in_data.kind;
        a        = i_in_data.bus_address;
        v        = i_in_data.write_data;
        // the unused fourth variant code behaves as the simple chip
        var_eff  = (r_chip_variant == VAR_ALIAS) ? VAR_SIMPLE : r_chip_variant;
        is_full  = (var_eff == VAR_FULL);
        p        = a[13:0];
        off      = p[9:0];
        ws       = (kind == KIND_PPU_WR);

        chr_win    = p[10 +: CW_W];
        chr_wr_win = a[11 +: CW_W];
        chr_b      = r_chr_bank[chr_win];
        chr_en     = (int'(chr_win) < CW_LO) ? r_low_en : r_high_en;
        nt_n       = p[11:10];
        nt_s       = r_nt_sel[nt_n];

        // pattern window bank or nametable select used as a ROM bank
        rom_bank = (p < 14'h2000) ? chr_b : nt_s;
        rom_base = {rom_bank, 10'd0} & r_chr_rom_mask;
        rom_addr = {1'b0, rom_base} + {9'd0, off};

        mir_eff = (var_eff == VAR_SIMPLE) ? (r_init_mirror ? MIR_HORIZ : MIR_VERT)
                                          : r_mirror;
        case (mir_eff)
            MIR_SINGLE_LO: page = 1'b0;
            MIR_VERT:      page = nt_n[0];
            MIR_SINGLE_HI: page = 1'b1;
            MIR_HORIZ:     page = nt_n[1];
            default:       page = 1'b0;
        endcase
        if (is_full) begin
            page = nt_s[0];
        end

        // fixed last bank sits in the top 8K slot
        case (a[14:13])
            2'd0:    prg_sel = r_prg_bank[0];
            2'd1:    prg_sel = r_prg_bank[1];
            2'd2:    prg_sel = r_prg_bank[2];
            default: prg_sel = r_prg_last;
        endcase

        cnt_inc = r_irq_count + 15'd1;

        n_prg_bank    = r_prg_bank;
        n_chr_bank    = r_chr_bank;
        n_nt_sel      = r_nt_sel;
        n_low_en      = r_low_en;
        n_high_en     = r_high_en;
        n_mirror      = r_mirror;
        n_irq_count   = r_irq_count;
        n_irq_enabled = r_irq_enabled;
        n_irq_pending = r_irq_pending;

        n_out                = '0;
        n_out.target         = TGT_NONE;

        case (kind)
            KIND_CPU_RD, KIND_CPU_WR: begin
                if (a[15]) begin
                    if (kind == KIND_CPU_WR) begin
                        // mapper register writes
                        if (!a[14]) begin
                            n_chr_bank[chr_wr_win] = v;
                        end else if (!a[13]) begin
                            if (is_full || a[12:11] == 2'd0) begin
                                n_nt_sel[a[12:11]] = v;
                            end
                        end else begin
                            case (a[12:11])
                                2'd0: begin
                                    n_prg_bank[0] = v[5:0];
                                    if (var_eff == VAR_MIRROR) begin
                                        n_mirror = v[7:6];
                                    end
                                end
                                2'd1: begin
                                    n_prg_bank[1] = v[5:0];
                                    n_low_en      = !v[6];
                                    n_high_en     = !v[7];
                                end
                                2'd2: n_prg_bank[2] = v[5:0];
                                default: ;  // audio area, ignored
                            endcase
                        end
                    end else begin
                        n_out.target         = TGT_PRGROM;
                        n_out.mapped_address = {prg_sel, a[12:0]};
                    end
                end else if (a[14:13] == 2'b11) begin
                    n_out.target         = TGT_PRGRAM;
                    n_out.mapped_address = {6'd0, a[12:0]};
                    n_out.write_strobe   = (kind == KIND_CPU_WR);
                end else if (a[14:12] == 3'b101 && is_full) begin
                    // IRQ counter registers
                    if (kind == KIND_CPU_WR) begin
                        if (!a[11]) begin
                            n_irq_count = {r_irq_count[14:8], v};
                        end else begin
                            n_irq_count   = {v[6:0], r_irq_count[7:0]};
                            n_irq_enabled = v[7];
                        end
                        n_irq_pending = 1'b0;
                    end else begin
                        n_out.target    = TGT_REG;
                        n_out.read_data = a[11] ? {r_irq_enabled, r_irq_count[14:8]}
                                                : r_irq_count[7:0];
                    end
                end
            end
            KIND_PPU_RD, KIND_PPU_WR: begin
                if (p < 14'h2000) begin
                    if (is_full && chr_b >= NT_RAM_SEL && chr_en) begin
                        n_out.target         = TGT_NTRAM;
                        n_out.mapped_address = {8'd0, chr_b[0], off};
                        n_out.write_strobe   = ws;
                    end else begin
                        n_out.target         = TGT_CHRROM;
                        n_out.mapped_address = rom_addr;
                    end
                end else if (p < 14'h3F00) begin
                    if (is_full && nt_s < NT_RAM_SEL) begin
                        n_out.target         = TGT_CHRROM;
                        n_out.mapped_address = rom_addr;
                    end else begin
                        n_out.target         = TGT_NTRAM;
                        n_out.mapped_address = {8'd0, page, off};
                        n_out.write_strobe   = ws;
                    end
                end
                // palette space maps to nothing
            end
            KIND_TICK: begin
                if (r_irq_enabled) begin
                    // count saturates at the top and raises the request
                    if (r_irq_count != IRQ_COUNT_MAX) begin
                        n_irq_count = cnt_inc;
                    end
                    if (r_irq_count == IRQ_COUNT_MAX || cnt_inc == IRQ_COUNT_MAX) begin
                        n_irq_enabled = 1'b0;
                        n_irq_pending = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        n_out.irq_line = n_irq_pending;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_variant <= VAR_FULL;
            r_init_mirror  <= 1'b1;
            r_chr_rom_mask <= '1;
            r_prg_last     <= '1;
            r_prg_bank[0]  <= 6'd0;
            r_prg_bank[1]  <= 6'd1;
            r_prg_bank[2]  <= 6'd2;
            for (int i = 0; i < CHR_WINDOWS; i++) begin
                r_chr_bank[i] <= 8'd0;
            end
            for (int i = 0; i < 4; i++) begin
                r_nt_sel[i] <= NT_RAM_SEL;
            end
            r_low_en      <= 1'b0;
            r_high_en     <= 1'b0;
            r_mirror      <= MIR_HORIZ;
            r_irq_count   <= 15'd0;
            r_irq_enabled <= 1'b0;
            r_irq_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_prg_bank    <= n_prg_bank;
                r_chr_bank    <= n_chr_bank;
                r_nt_sel      <= n_nt_sel;
                r_low_en      <= n_low_en;
                r_high_en     <= n_high_en;
                r_mirror      <= n_mirror;
                r_irq_count   <= n_irq_count;
                r_irq_enabled <= n_irq_enabled;
                r_irq_pending <= n_irq_pending;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_CHIP_VARIANT: r_chip_variant <= pwdata[1:0];
                    REG_INIT_MIRROR: begin
                        // also reloads the live mirroring mode
                        r_init_mirror <= pwdata[0];
                        r_mirror      <= pwdata[0] ? MIR_HORIZ : MIR_VERT;
                    end
                    REG_CHR_ROM_MASK: r_chr_rom_mask <= pwdata[17:0];
                    REG_PRG_LAST:     r_prg_last     <= pwdata[5:0];
                    default: ;
                endcase
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    // saturation clears enable while setting pending; a write clears pending
    a_irq_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_irq_pending && r_irq_enabled))
        else $error("irq pending and enabled both set");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted transaction left no result");

    a_irq_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out.irq_line == r_irq_pending))
        else $error("irq line does not follow pending state");

    a_ntram_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.target == TGT_NTRAM) |-> (r_out.mapped_address[18:11] == 8'd0))
        else $error("nametable address beyond 2K");

    a_none_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.target == TGT_NONE || r_out.target == TGT_REG))
            |-> (r_out.mapped_address == 19'd0 && !r_out.write_strobe))
        else $error("unmapped result carries address or strobe");
`endif

endmodule

`default_nettype wire
